### design/swm_pkg.sv
// shared types and constants for the sliding window maximum block
`default_nettype none

package swm_pkg;

   localparam int WINDOW_MAX  = 64;
   localparam int SAMPLE_BITS = 32;
   localparam int POS_BITS    = 16;
   localparam int WIN_BITS    = 7;
   localparam int IDX_BITS    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1);
   localparam int SUM_BITS    = CNT_BITS + 1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          end_of_sequence;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] window_max;
      logic                          last_result;
   } rsp_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] value;
      logic [POS_BITS-1:0]           position;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_FRONT_RD  = 8'b0000_0010,
      ST_FRONT_CHK = 8'b0000_0100,
      ST_BACK_RD   = 8'b0000_1000,
      ST_BACK_CHK  = 8'b0001_0000,
      ST_APPEND    = 8'b0010_0000,
      ST_OUT_RD    = 8'b0100_0000,
      ST_OUT_WR    = 8'b1000_0000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // latch the accepted transaction
      logic rd_back;     // read the back entry, else the front entry
      logic drop_front;
      logic drop_back;
      logic append;
      logic emit;        // finish the transaction
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic expired;     // front entry read last cycle is outside the window
      logic smaller;     // back entry read last cycle is below the new sample
      logic out_blocked; // result register full and stalled
   } status_type;

endpackage

`default_nettype wire

### design/sliding_window_max_core.sv
// top level: running maximum over a sliding window of signed samples
// sequence: accept, front expiry walk, back pruning walk, append, then a front readout
//   into the result register; every dropped entry costs a read state and a check state
// a new sample is accepted only after the previous transaction has finished, and the
//   finish waits while the previous result is still stalled in the result register
// reset: synchronous, active high; clears pointers, position, fill flag, result valid
`default_nettype none

module sliding_window_max_core
   import swm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // configuration
   input  wire logic                csr_wr_en,
   input  wire logic [WIN_BITS-1:0] csr_wr_data,
   // sample transactions
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire req_type             req_payload,
   // result transactions
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output rsp_type                  rsp_payload
);

   // reset also sets window_size to 1; deque memory contents are not cleared

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: front expiry walk, back pruning walk, append, front readout
   swm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // deque memory, head and count pointers, result register
   // the result register lets a new transaction in while a result is stalled
   swm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

### design/swm_ram.sv
// generic single write port memory with registered read
`default_nettype none

module swm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/swm_ctrl.sv
// controller state machine for the sliding window maximum block
`default_nettype none

module swm_ctrl
   import swm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_FRONT_RD;
            end
         end
         ST_FRONT_RD: begin
            state_in = status.empty ? ST_BACK_RD : ST_FRONT_CHK;
         end
         ST_FRONT_CHK: begin
            if (status.expired) begin
               cmd.drop_front = 1'b1;
               state_in       = ST_FRONT_RD;
            end else begin
               state_in = ST_BACK_RD;
            end
         end
         ST_BACK_RD: begin
            cmd.rd_back = 1'b1;
            state_in    = status.empty ? ST_APPEND : ST_BACK_CHK;
         end
         ST_BACK_CHK: begin
            if (status.smaller) begin
               cmd.drop_back = 1'b1;
               state_in      = ST_BACK_RD;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = ST_OUT_RD;
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_WR;
         end
         ST_OUT_WR: begin
            if (!status.out_blocked) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### design/swm_datapath.sv
// deque storage, pointers, window register and result register
`default_nettype none

module swm_datapath
   import swm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [WIN_BITS-1:0] csr_wr_data,
   input  wire req_type             req_payload,
   input  wire cmd_type             cmd,
   output status_type               status,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output rsp_type                  rsp_payload
);

   logic [WIN_BITS-1:0]    window_ff;
   logic [IDX_BITS-1:0]    head_ff, head_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [POS_BITS-1:0]    pos_ff, pos_in;
   logic                   filled_ff, filled_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff;
   req_type                item_ff;

   logic [WIN_BITS-1:0]    win;
   logic [IDX_BITS-1:0]    head_next;
   logic [SUM_BITS-1:0]    back_sum, slot_sum;
   logic [IDX_BITS-1:0]    back_idx, slot_idx, rd_addr;
   logic [POS_BITS-1:0]    age;
   logic                   full, filled_now, produce;
   entry_type              rd_entry, wr_entry;

   assign win = (window_ff > WIN_BITS'(WINDOW_MAX)) ? WIN_BITS'(WINDOW_MAX) : window_ff;

   assign head_next = (head_ff == IDX_BITS'(WINDOW_MAX - 1)) ? '0 : head_ff + 1'b1;

   // back = head + count - 1, slot = head + count, both modulo depth
   assign back_sum = SUM_BITS'(head_ff) + SUM_BITS'(count_ff) - SUM_BITS'(1);
   assign slot_sum = SUM_BITS'(head_ff) + SUM_BITS'(count_ff);
   assign back_idx = (back_sum >= SUM_BITS'(WINDOW_MAX)) ?
                     IDX_BITS'(back_sum - SUM_BITS'(WINDOW_MAX)) : IDX_BITS'(back_sum);
   assign slot_idx = (slot_sum >= SUM_BITS'(WINDOW_MAX)) ?
                     IDX_BITS'(slot_sum - SUM_BITS'(WINDOW_MAX)) : IDX_BITS'(slot_sum);

   assign rd_addr  = cmd.rd_back ? back_idx : head_ff;
   assign full     = (count_ff == CNT_BITS'(WINDOW_MAX));

   assign wr_entry.value    = item_ff.sample;
   assign wr_entry.position = pos_ff;

   swm_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_deque_ram (
      .clock   (clock),
      .wr_en   (cmd.append),
      .wr_addr (slot_idx),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign age        = pos_ff - rd_entry.position;
   assign filled_now = (win != '0) && (pos_ff >= (POS_BITS'(win) - POS_BITS'(1)));
   assign produce    = (win != '0) && (filled_ff || filled_now);

   assign status.empty       = (count_ff == '0);
   assign status.expired     = (age >= POS_BITS'(win));
   assign status.smaller     = ($signed(rd_entry.value) < $signed(item_ff.sample));
   assign status.out_blocked = rsp_valid_ff && rsp_stall;

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      filled_in    = filled_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.drop_front) begin
         head_in  = head_next;
         count_in = count_ff - 1'b1;
      end
      if (cmd.drop_back) begin
         count_in = count_ff - 1'b1;
      end
      if (cmd.append) begin
         // full deque drops its oldest entry, the slot then reuses the old head
         if (full) begin
            head_in = head_next;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.emit) begin
         if (produce) begin
            rsp_valid_in = 1'b1;
         end
         if (item_ff.end_of_sequence) begin
            head_in   = '0;
            count_in  = '0;
            pos_in    = '0;
            filled_in = 1'b0;
         end else begin
            pos_in    = pos_ff + 1'b1;
            filled_in = filled_ff || filled_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WIN_BITS'(1);
         head_ff      <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         filled_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
         end
         head_ff      <= head_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_payload;
      end
      if (cmd.emit && produce) begin
         rsp_ff.window_max  <= rd_entry.value;
         rsp_ff.last_result <= item_ff.end_of_sequence;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire
